// ===== src/mpo_pkg.sv =====
// ----------------------------------------------------------------------------
// MPPT tracker package
// Shared widths, codes, reset values and item types of the P&O tracker.
// ----------------------------------------------------------------------------
package mpo_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned SmpW    = 8;
  localparam int unsigned CfgIdxW = 3;

  // Width of v/1000 and of ceil(v/10) for a 32-bit v.
  localparam int unsigned MilliW  = 23;
  localparam int unsigned TenthW  = 29;

  // Reciprocals for exact constant division (verified error bounds).
  // floor(2v/5)    = (2v * R) >> 35
  localparam logic [33:0] RecipFifth    = 34'd6871947674;
  localparam int unsigned ShiftFifth    = 35;
  // floor(v/1000)  = (v * R) >> 38
  localparam logic [28:0] RecipThousand = 29'd274877907;
  localparam int unsigned ShiftThousand = 38;
  // floor(y/10)    = (y * R) >> 35, y < 2^33
  localparam logic [31:0] RecipTenth    = 32'd3435973837;
  localparam int unsigned ShiftTenth    = 35;

  localparam logic [SmpW-1:0] SettleSamples = 8'd5;

  // Register reset values
  localparam logic [DataW-1:0] RstVoltThr      = 32'd10;
  localparam logic [DataW-1:0] RstCurrThr      = 32'd10;
  localparam logic [DataW-1:0] RstInterval     = 32'd100;
  localparam logic [DataW-1:0] RstMaxStepHigh  = 32'd1000;
  localparam logic [DataW-1:0] RstMaxStepLow   = 32'd200;
  localparam logic [DataW-1:0] RstMinStepHigh  = 32'd10;
  localparam logic [DataW-1:0] RstMinStepLow   = 32'd2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CMD_HOLD         = 3'd0,
    CMD_ZERO_CURRENT = 3'd1,
    CMD_SET          = 3'd2,
    CMD_RAISE        = 3'd3,
    CMD_LOWER        = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VOLT_THR       = 3'd0,
    CFG_CURR_THR       = 3'd1,
    CFG_INTERVAL       = 3'd2,
    CFG_MAX_STEP_HIGH  = 3'd3,
    CFG_MAX_STEP_LOW   = 3'd4,
    CFG_MIN_STEP_HIGH  = 3'd5,
    CFG_MIN_STEP_LOW   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic             opcode;
    logic [DataW-1:0] start_voltage;
    logic [DataW-1:0] meas_voltage;
    logic [DataW-1:0] meas_current;
    logic [DataW-1:0] meas_power;
    logic [DataW-1:0] time_ms;
    logic [SmpW-1:0]  sample_number;
    logic             high_range;
  } in_item_t;

  typedef struct packed {
    cmd_e             command;
    logic [DataW-1:0] amount;
  } out_item_t;

  typedef struct packed {
    logic [DataW-1:0] volt_thr;
    logic [DataW-1:0] curr_thr;
    logic [DataW-1:0] interval;
    logic [DataW-1:0] max_step_high;
    logic [DataW-1:0] max_step_low;
    logic [DataW-1:0] min_step_high;
    logic [DataW-1:0] min_step_low;
  } cfg_regs_t;

  // Item after preparation: everything that does not depend on tracker state.
  typedef struct packed {
    logic             opcode;
    logic [DataW-1:0] start_voltage;
    logic [DataW-1:0] meas_power;
    logic [DataW-1:0] time_ms;
    logic [SmpW-1:0]  sample_number;
    logic             low_volt;
    logic             low_curr;
    logic [DataW-1:0] step_min;
    logic [DataW-1:0] step_lo;
    logic [DataW-1:0] step_hi;
    logic [DataW-1:0] open_ninety;
  } prep_item_t;

endpackage

// ===== src/mpo_in_if.sv =====
// ----------------------------------------------------------------------------
// Measurement item channel
// Valid/ready channel carrying one tracker input item.
// ----------------------------------------------------------------------------
interface mpo_in_if
  import mpo_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== src/mpo_out_if.sv =====
// ----------------------------------------------------------------------------
// Load command channel
// Valid/ready channel carrying one tracker result item.
// ----------------------------------------------------------------------------
interface mpo_out_if
  import mpo_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== src/mpo_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready register write: register index and write data.
// ----------------------------------------------------------------------------
interface mpo_cfg_if
  import mpo_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] reg_index;
  logic [DataW-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== src/mpo_prep.sv =====
// ----------------------------------------------------------------------------
// Measurement preparation pipeline
// Input register, constant-division stage and step-limit stage.
// ----------------------------------------------------------------------------
module mpo_prep
  import mpo_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mpo_in_if.sink     in_i,
  input  cfg_regs_t  cfg_regs_i,
  output logic       prep_valid_o,
  output prep_item_t prep_item_o,
  input  logic       prep_ready_i
);

  typedef struct packed {
    in_item_t          item;
    logic [DataW-1:0]  top;      // floor(2v/5)
    logic [MilliW-1:0] bottom;   // floor(v/1000)
    logic [TenthW-1:0] tenth_up; // ceil(v/10)
  } div_item_t;

  logic       s1_valid_q, s2_valid_q, s3_valid_q;
  logic       s1_en, s2_en, s3_en;
  in_item_t   s1_q;
  div_item_t  s2_d, s2_q;
  prep_item_t s3_d, s3_q;

  assign s3_en = !s3_valid_q || prep_ready_i;
  assign s2_en = !s2_valid_q || s3_en;
  assign s1_en = !s1_valid_q || s2_en;

  assign in_i.ready   = s1_en;
  assign prep_valid_o = s3_valid_q;
  assign prep_item_o  = s3_q;

  // Stage 2: reciprocal multiplications
  logic [DataW:0]     dbl_v;
  logic [DataW+33:0]  prod_top;
  logic [DataW+28:0]  prod_bottom;
  logic [DataW:0]     v_plus9;
  logic [DataW+32:0]  prod_tenth;

  always_comb begin
    dbl_v       = {s1_q.meas_voltage, 1'b0};
    prod_top    = {33'd0, dbl_v} * {{DataW{1'b0}}, RecipFifth};
    prod_bottom = {29'd0, s1_q.meas_voltage} * {{DataW{1'b0}}, RecipThousand};
    v_plus9     = {1'b0, s1_q.meas_voltage} + 33'd9;
    prod_tenth  = {32'd0, v_plus9} * {{(DataW+1){1'b0}}, RecipTenth};

    s2_d.item     = s1_q;
    s2_d.top      = prod_top[ShiftFifth +: DataW];
    s2_d.bottom   = prod_bottom[ShiftThousand +: MilliW];
    s2_d.tenth_up = prod_tenth[ShiftTenth +: TenthW];
  end

  // Stage 3: clamp window [lo, hi] of the step size, flags
  logic [DataW-1:0] step_max, step_min, bottom_w, lo_a, hi_a, hi_b;

  always_comb begin
    step_max = s2_q.item.high_range ? cfg_regs_i.max_step_high : cfg_regs_i.max_step_low;
    step_min = s2_q.item.high_range ? cfg_regs_i.min_step_high : cfg_regs_i.min_step_low;
    bottom_w = {{(DataW-MilliW){1'b0}}, s2_q.bottom};

    // clamp of a zero step
    lo_a = (bottom_w > step_max) ? step_max : bottom_w;
    // clamp of an all-ones step
    hi_a = (s2_q.top > bottom_w) ? s2_q.top : bottom_w;
    hi_b = (hi_a > step_max) ? step_max : hi_a;

    s3_d.opcode        = s2_q.item.opcode;
    s3_d.start_voltage = s2_q.item.start_voltage;
    s3_d.meas_power    = s2_q.item.meas_power;
    s3_d.time_ms       = s2_q.item.time_ms;
    s3_d.sample_number = s2_q.item.sample_number;
    s3_d.low_volt      = s2_q.item.meas_voltage < cfg_regs_i.volt_thr;
    s3_d.low_curr      = s2_q.item.meas_current < cfg_regs_i.curr_thr;
    s3_d.step_min      = step_min;
    s3_d.step_lo       = (lo_a < step_min) ? step_min : lo_a;
    s3_d.step_hi       = (hi_b < step_min) ? step_min : hi_b;
    s3_d.open_ninety   = s2_q.item.meas_voltage -
                         {{(DataW-TenthW){1'b0}}, s2_q.tenth_up};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_i.valid;
      if (s2_en) s2_valid_q <= s1_valid_q;
      if (s3_en) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_i.valid) s1_q <= in_i.item;
    if (s2_en && s1_valid_q) s2_q <= s2_d;
    if (s3_en && s2_valid_q) s3_q <= s3_d;
  end

endmodule

// ===== src/mppt_perturb_observe_tracker.sv =====
// ----------------------------------------------------------------------------
// Perturb-and-observe MPPT tracker
// Voltage-mode maximum power point tracker with adaptive step size.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns exactly one command item for each, in
// order. An item passes through four registers: input register, a stage with
// the three reciprocal multiplications (40 %, 0.1 % and 10 % of the measured
// voltage), a stage that works out the step clamp window and the low
// voltage/current flags, and the result register, where the tracker state is
// read and updated. A new item is taken every cycle as long as the sink
// keeps up; each stage stalls only when the one after it is full.
// Configuration writes are taken at any time (ready is always high) but must
// only be issued with no items in flight, since the prepared stages use the
// register values directly.
// ----------------------------------------------------------------------------
module mppt_perturb_observe_tracker
  import mpo_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  mpo_in_if.sink    in_i,
  mpo_out_if.source out_o,
  mpo_cfg_if.sink   cfg_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_regs_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volt_thr      <= RstVoltThr;
      cfg_q.curr_thr      <= RstCurrThr;
      cfg_q.interval      <= RstInterval;
      cfg_q.max_step_high <= RstMaxStepHigh;
      cfg_q.max_step_low  <= RstMaxStepLow;
      cfg_q.min_step_high <= RstMinStepHigh;
      cfg_q.min_step_low  <= RstMinStepLow;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_VOLT_THR:      cfg_q.volt_thr      <= cfg_i.wdata;
        CFG_CURR_THR:      cfg_q.curr_thr      <= cfg_i.wdata;
        CFG_INTERVAL:      cfg_q.interval      <= cfg_i.wdata;
        CFG_MAX_STEP_HIGH: cfg_q.max_step_high <= cfg_i.wdata;
        CFG_MAX_STEP_LOW:  cfg_q.max_step_low  <= cfg_i.wdata;
        CFG_MIN_STEP_HIGH: cfg_q.min_step_high <= cfg_i.wdata;
        CFG_MIN_STEP_LOW:  cfg_q.min_step_low  <= cfg_i.wdata;
        default: ;         // unmapped index, write ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Preparation pipeline (state independent)
  // --------------------------------------------------------------------------
  logic       prep_valid;
  prep_item_t prep;
  logic       out_en;
  logic       fire;

  mpo_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_regs_i   (cfg_q),
    .prep_valid_o (prep_valid),
    .prep_item_o  (prep),
    .prep_ready_i (out_en)
  );

  // Result register is free or being emptied this cycle
  assign out_en = !out_o.valid || out_o.ready;
  assign fire   = prep_valid && out_en;

  // --------------------------------------------------------------------------
  // Tracker state
  // --------------------------------------------------------------------------
  logic             ready_q, ready_d;           // tracking initialised
  logic [SmpW-1:0]  saved_q, saved_d;           // sample number at last start
  logic [DataW-1:0] last_time_q, last_time_d;   // time of last P&O step
  logic [DataW-1:0] pwr_prev_q, pwr_prev_d;
  logic [DataW-1:0] pwr_prev2_q, pwr_prev2_d;
  logic             up_q, up_d;                 // planned direction
  logic             earlier_up_q, earlier_up_d; // direction one step back
  logic [DataW-1:0] step_q, step_d;

  logic             out_valid_q;
  out_item_t        out_q, out_d;

  // Step decision terms
  logic [DataW-1:0] elapsed;
  logic             interval_done;
  logic [DataW-1:0] step_base;
  logic [DataW-1:0] half_sum;
  logic             dir_new;
  logic [DataW:0]   grow_sum;
  logic [DataW-1:0] step_adj;
  logic [DataW-1:0] step_new;

  always_comb begin
    elapsed       = prep.time_ms - last_time_q;
    interval_done = elapsed > cfg_q.interval;

    // Low voltage or low current restart from the clamped minimum
    step_base = (prep.low_volt || prep.low_curr) ? prep.step_lo : step_q;

    // Power falls away from the trend: (p/2 + pp2/2) < pp means peak passed
    half_sum = {1'b0, prep.meas_power[DataW-1:1]} + {1'b0, pwr_prev2_q[DataW-1:1]};

    priority if (prep.low_volt) begin
      dir_new = 1'b1;
    end else if (prep.low_curr) begin
      dir_new = 1'b0;
    end else if (up_q != earlier_up_q) begin
      dir_new = (half_sum < pwr_prev_q) ? earlier_up_q : up_q;
    end else if (pwr_prev_q > prep.meas_power) begin
      dir_new = !up_q;
    end else begin
      dir_new = up_q;
    end

    // Grow while the direction holds, shrink on reversal (both saturating)
    grow_sum = {1'b0, step_base} + {1'b0, prep.step_min};
    if (dir_new == earlier_up_q) begin
      step_adj = grow_sum[DataW] ? {DataW{1'b1}} : grow_sum[DataW-1:0];
    end else begin
      step_adj = (step_base > prep.step_min) ? step_base - prep.step_min : '0;
    end

    // Clamp chain collapsed to one window computed upstream
    if (step_adj < prep.step_lo) begin
      step_new = prep.step_lo;
    end else if (step_adj > prep.step_hi) begin
      step_new = prep.step_hi;
    end else begin
      step_new = step_adj;
    end
  end

  always_comb begin
    ready_d      = ready_q;
    saved_d      = saved_q;
    last_time_d  = last_time_q;
    pwr_prev_d   = pwr_prev_q;
    pwr_prev2_d  = pwr_prev2_q;
    up_d         = up_q;
    earlier_up_d = earlier_up_q;
    step_d       = step_q;
    out_d.command = CMD_HOLD;
    out_d.amount  = '0;

    priority if (prep.opcode == OP_START) begin
      pwr_prev_d  = prep.meas_power;
      pwr_prev2_d = prep.meas_power;
      step_d      = prep.step_lo;
      saved_d     = prep.sample_number;
      if (prep.start_voltage == '0) begin
        // automatic start: zero the current, wait for open-circuit voltage
        out_d.command = CMD_ZERO_CURRENT;
        ready_d       = 1'b0;
      end else begin
        out_d.command = CMD_SET;
        out_d.amount  = prep.start_voltage;
        ready_d       = 1'b1;
      end
    end else if (!ready_q) begin
      // settling: set 90 % of open-circuit voltage five samples on
      if (prep.sample_number == saved_q + SettleSamples) begin
        out_d.command = CMD_SET;
        out_d.amount  = prep.open_ninety;
        saved_d       = prep.sample_number;
        ready_d       = 1'b1;
      end
    end else if (interval_done) begin
      up_d          = dir_new;
      earlier_up_d  = up_q;
      step_d        = step_new;
      pwr_prev2_d   = pwr_prev_q;
      pwr_prev_d    = prep.meas_power;
      last_time_d   = prep.time_ms;
      out_d.command = dir_new ? CMD_RAISE : CMD_LOWER;
      out_d.amount  = step_new;
    end else begin
      // interval not yet elapsed: hold, state kept
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q      <= 1'b0;
      saved_q      <= '0;
      last_time_q  <= '0;
      pwr_prev_q   <= '0;
      pwr_prev2_q  <= '0;
      up_q         <= 1'b0;
      earlier_up_q <= 1'b0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_en) out_valid_q <= prep_valid;
      if (fire) begin
        ready_q      <= ready_d;
        saved_q      <= saved_d;
        last_time_q  <= last_time_d;
        pwr_prev_q   <= pwr_prev_d;
        pwr_prev2_q  <= pwr_prev2_d;
        up_q         <= up_d;
        earlier_up_q <= earlier_up_d;
        step_q       <= step_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

endmodule
